// File: hw/rtl/mce_pkg.sv
// Package for the Morse code encoder: symbol codes, sequencer states,
// the character code table and the load request passed to the serializer.
// No dependencies.
package mce_pkg;

  // Output symbol codes.
  typedef enum logic [2:0] {
    SYM_DOT   = 3'd0,
    SYM_DASH  = 3'd1,
    SYM_SLASH = 3'd2,
    SYM_SPACE = 3'd3,
    SYM_COMMA = 3'd4
  } sym_t;

  // Serializer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } mce_state_t;

  localparam int unsigned MaxElems = 6;

  // Code of one character: element count and elements, first one at the MSB,
  // a 1 being a dash.
  typedef struct packed {
    logic [2:0]          len;
    logic [MaxElems-1:0] elems;
  } code_t;

  // Load request from the front end to the serializer.
  typedef struct packed {
    logic                lead;      // Comma gap ahead of the code.
    logic                space;     // Word space instead of a code.
    logic [MaxElems-1:0] elems;
    logic [3:0]          body_cnt;  // Elements plus slashes to send.
    logic                trail;     // Comma gap after the code.
    logic                none;      // Character causes no symbol.
  } load_t;

  function automatic code_t code_of(input logic [7:0] ch);
    code_t c;
    c = '{len: 3'd0, elems: 6'b000000};
    unique case (ch)
      "a": c = '{3'd2, 6'b010000};
      "b": c = '{3'd4, 6'b100000};
      "w": c = '{3'd3, 6'b011000};
      "g": c = '{3'd3, 6'b110000};
      "d": c = '{3'd3, 6'b100000};
      "e": c = '{3'd1, 6'b000000};
      "v": c = '{3'd4, 6'b000100};
      "z": c = '{3'd4, 6'b110000};
      "i": c = '{3'd2, 6'b000000};
      "j": c = '{3'd4, 6'b011100};
      "k": c = '{3'd3, 6'b101000};
      "l": c = '{3'd4, 6'b010000};
      "m": c = '{3'd2, 6'b110000};
      "n": c = '{3'd2, 6'b100000};
      "o": c = '{3'd3, 6'b111000};
      "p": c = '{3'd4, 6'b011000};
      "r": c = '{3'd3, 6'b010000};
      "s": c = '{3'd3, 6'b000000};
      "t": c = '{3'd1, 6'b100000};
      "u": c = '{3'd3, 6'b001000};
      "f": c = '{3'd4, 6'b001000};
      "h": c = '{3'd4, 6'b000000};
      "c": c = '{3'd4, 6'b101000};
      "q": c = '{3'd4, 6'b110100};
      "y": c = '{3'd4, 6'b101100};
      "x": c = '{3'd4, 6'b100100};
      "1": c = '{3'd5, 6'b011110};
      "2": c = '{3'd5, 6'b001110};
      "3": c = '{3'd5, 6'b000110};
      "4": c = '{3'd5, 6'b000010};
      "5": c = '{3'd5, 6'b000000};
      "6": c = '{3'd5, 6'b100000};
      "7": c = '{3'd5, 6'b110000};
      "8": c = '{3'd5, 6'b111000};
      "9": c = '{3'd5, 6'b111100};
      "0": c = '{3'd5, 6'b111110};
      ".": c = '{3'd6, 6'b000000};
      ",": c = '{3'd6, 6'b010101};
      ":": c = '{3'd6, 6'b111000};
      ";": c = '{3'd6, 6'b101010};
      "(": c = '{3'd6, 6'b101101};
      ")": c = '{3'd6, 6'b101101};
      "\"": c = '{3'd6, 6'b010010};
      "-": c = '{3'd6, 6'b100001};
      "/": c = '{3'd5, 6'b100100};
      "?": c = '{3'd6, 6'b001100};
      "!": c = '{3'd6, 6'b110011};
      "@": c = '{3'd6, 6'b011010};
      default: c = '{3'd0, 6'b000000};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/mce_serializer.sv
// Symbol serializer of the Morse code encoder: a small sequencer that
// walks one loaded character code and sends one symbol per cycle
// while the receiver is ready. Depends on mce_pkg.
module mce_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mce_pkg::load_t load_req,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_symbol,
  output logic           out_last_of_run,
  output logic           out_no_symbol
);
  import mce_pkg::*;

  mce_state_t          st_r, st_nxt;
  logic                lead_r, lead_nxt;
  logic                space_r, space_nxt;
  logic [MaxElems-1:0] elems_r, elems_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                sep_r, sep_nxt;
  logic                trail_r, trail_nxt;
  logic                none_r, none_nxt;
  logic                out_valid_r, out_valid_nxt;
  sym_t                sym_r, sym_nxt;
  logic                last_r, last_nxt;
  logic                nosym_r, nosym_nxt;
  logic                slot_free;
  logic                advance;

  assign slot_free = !out_valid_r || out_ready;
  assign advance   = (st_r == ST_RUN) && slot_free;

  // Pick the next symbol, work out what remains and step the sequencer.
  always_comb begin
    st_nxt    = st_r;
    lead_nxt  = lead_r;
    space_nxt = space_r;
    elems_nxt = elems_r;
    cnt_nxt   = cnt_r;
    sep_nxt   = sep_r;
    trail_nxt = trail_r;
    none_nxt  = none_r;
    sym_nxt   = SYM_DOT;
    nosym_nxt = 1'b0;
    if (lead_r) begin
      sym_nxt  = SYM_COMMA;
      lead_nxt = 1'b0;
    end else if (space_r) begin
      sym_nxt   = SYM_SPACE;
      space_nxt = 1'b0;
    end else if (cnt_r != 4'd0) begin
      if (sep_r) begin
        sym_nxt = SYM_SLASH;
        sep_nxt = 1'b0;
      end else begin
        sym_nxt   = elems_r[MaxElems-1] ? SYM_DASH : SYM_DOT;
        elems_nxt = {elems_r[MaxElems-2:0], 1'b0};
        sep_nxt   = 1'b1;
      end
      cnt_nxt = cnt_r - 4'd1;
    end else if (trail_r) begin
      sym_nxt   = SYM_COMMA;
      trail_nxt = 1'b0;
    end else begin
      nosym_nxt = 1'b1;
      none_nxt  = 1'b0;
    end
    last_nxt = !(lead_nxt || space_nxt || (cnt_nxt != 4'd0) || trail_nxt || none_nxt);

    unique case (st_r)
      ST_IDLE: begin
        if (load) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && last_nxt) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencer registers: loaded from a request, stepped as symbols leave.
  always_ff @(posedge clk) begin
    if (load && st_r == ST_IDLE) begin
      lead_r  <= load_req.lead;
      space_r <= load_req.space;
      elems_r <= load_req.elems;
      cnt_r   <= load_req.body_cnt;
      sep_r   <= 1'b0;
      trail_r <= load_req.trail;
      none_r  <= load_req.none;
    end else if (advance) begin
      lead_r  <= lead_nxt;
      space_r <= space_nxt;
      elems_r <= elems_nxt;
      cnt_r   <= cnt_nxt;
      sep_r   <= sep_nxt;
      trail_r <= trail_nxt;
      none_r  <= none_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      sym_r   <= sym_nxt;
      last_r  <= last_nxt;
      nosym_r <= nosym_nxt;
    end
  end

  assign busy            = (st_r == ST_RUN);
  assign out_valid       = out_valid_r;
  assign out_symbol      = sym_r;
  assign out_last_of_run = last_r;
  assign out_no_symbol   = nosym_r;

endmodule

// File: hw/rtl/morse_code_encoder.sv
// Morse code encoder top level: takes one character per request and sends
// its Morse symbols through mce_serializer, one result per cycle while the
// receiver is ready. The first result is registered twice: the request loads
// the sequencer registers, then the first symbol enters the output register.
// A new character is taken only once the serializer has left its run state.
// Reset (synchronous, rst_n low) clears the pending letter gap and all valids.
module morse_code_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_symbol,
  output logic       out_last_of_run,
  output logic       out_no_symbol
);
  import mce_pkg::*;

  logic       gap_pending_r, gap_pending_nxt;
  logic       accept;
  logic       busy;
  logic [7:0] ch;
  logic       is_space;
  code_t      code;
  load_t      req;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  // Fold upper case to lower case and look up the code.
  always_comb begin
    ch = in_char_code;
    if (in_char_code >= "A" && in_char_code <= "Z") begin
      ch = in_char_code + 8'd32;
    end
    is_space = (ch == " ");
    code     = code_of(ch);
  end

  // Build the serializer request and the next gap state.
  always_comb begin
    req.lead     = gap_pending_r && !is_space;
    req.space    = is_space;
    req.elems    = code.elems;
    req.body_cnt = (code.len == 3'd0) ? 4'd0 : ({code.len, 1'b0} - 4'd1);
    req.trail    = in_is_final && !is_space;
    req.none     = !req.lead && !req.space && (code.len == 3'd0) && !req.trail;
    gap_pending_nxt = in_is_final ? 1'b0 : !is_space;
  end

  // Gap pending flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_pending_r <= 1'b0;
    end else if (accept) begin
      gap_pending_r <= gap_pending_nxt;
    end
  end

  mce_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept),
    .load_req        (req),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run),
    .out_no_symbol   (out_no_symbol)
  );

  // A no-symbol result is the only result of its item and carries a dot code.
  a_nosym_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_symbol |-> out_last_of_run && out_symbol == SYM_DOT)
    else $error("no-symbol result not alone");

  // An accepted request blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // Symbol codes stay in range.
  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_symbol <= SYM_COMMA)
    else $error("symbol code out of range");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for morse_code_encoder: random valid/ready traffic on both sides.
// Predicts each character's symbols in a local encoder model and checks them in order.
// Depends on mce_pkg (symbol codes) and the morse_code_encoder RTL.
module testbench;
  import mce_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_req_t;

  typedef struct {
    sym_t sym;
    logic last;
    logic none;
  } morse_sym_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_symbol;
  logic       out_last_of_run;
  logic       out_no_symbol;

  char_req_t  char_reqs[$];
  morse_sym_t symbols_due[$];
  logic       gap_owed = 1'b0;
  int         errors = 0;
  int         cycle_cnt = 0;
  int         chars_sent = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  morse_code_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run),
    .out_no_symbol   (out_no_symbol)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Dot/dash pattern of a lower-case character; an empty string means unknown.
  function automatic string morse_pattern(input logic [7:0] ch);
    case (ch)
      "a": return "./-";
      "b": return "-/././.";
      "c": return "-/./-/.";
      "d": return "-/./.";
      "e": return ".";
      "f": return "././-/.";
      "g": return "-/-/.";
      "h": return "./././.";
      "i": return "./.";
      "j": return "./-/-/-";
      "k": return "-/./-";
      "l": return "./-/./.";
      "m": return "-/-";
      "n": return "-/.";
      "o": return "-/-/-";
      "p": return "./-/-/.";
      "q": return "-/-/./-";
      "r": return "./-/.";
      "s": return "././.";
      "t": return "-";
      "u": return "././-";
      "v": return "./././-";
      "w": return "./-/-";
      "x": return "-/././-";
      "y": return "-/./-/-";
      "z": return "-/-/./.";
      "0": return "-/-/-/-/-";
      "1": return "./-/-/-/-";
      "2": return "././-/-/-";
      "3": return "./././-/-";
      "4": return "././././-";
      "5": return "././././.";
      "6": return "-/./././.";
      "7": return "-/-/././.";
      "8": return "-/-/-/./.";
      "9": return "-/-/-/-/.";
      ".": return "./././././.";
      ",": return "./-/./-/./-";
      ":": return "-/-/-/././.";
      ";": return "-/./-/./-/.";
      "(": return "-/./-/-/./-";
      ")": return "-/./-/-/./-";
      "\"": return "./-/././-/.";
      "-": return "-/././././-";
      "/": return "-/././-/.";
      "?": return "././-/-/./.";
      "!": return "-/-/././-/-";
      "@": return "./-/-/./-/.";
      " ": return " ";
      default: return "";
    endcase
  endfunction

  // Work out the symbols one accepted character causes and queue them.
  task automatic encode_char(input logic [7:0] raw, input logic fin);
    logic [7:0] ch;
    string      pat;
    sym_t       run[$];
    bit         is_space;
    morse_sym_t e;
    ch = raw;
    if (ch >= "A" && ch <= "Z") ch = ch + 8'd32;
    is_space = (ch == " ");
    if (gap_owed && !is_space) run.push_back(SYM_COMMA);
    pat = morse_pattern(ch);
    for (int k = 0; k < pat.len() && run.size() < 12; k++) begin
      case (pat[k])
        ".": run.push_back(SYM_DOT);
        "-": run.push_back(SYM_DASH);
        "/": run.push_back(SYM_SLASH);
        default: run.push_back(SYM_SPACE);
      endcase
    end
    // A final character closes the message; otherwise a gap is owed after non-spaces.
    if (fin) begin
      if (!is_space) run.push_back(SYM_COMMA);
      gap_owed = 1'b0;
    end else begin
      gap_owed = !is_space;
    end
    if (run.size() == 0) begin
      e = '{sym: SYM_DOT, last: 1'b1, none: 1'b1};
      symbols_due.push_back(e);
    end else begin
      foreach (run[i]) begin
        e = '{sym: run[i], last: (i == run.size() - 1), none: 1'b0};
        symbols_due.push_back(e);
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at result %0d: %s", results_seen, what);
    errors++;
  endtask

  task automatic queue_char(input logic [7:0] ch, input logic fin);
    char_reqs.push_back('{ch: ch, fin: fin});
  endtask

  // Driver: presents queued requests, idling at random outside a calm window.
  always @(posedge clk) begin : driver
    bit idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_char(in_char_code, in_is_final);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || in_ready) begin
        idle = (chars_sent < 150 || chars_sent >= 200) && ($urandom_range(99) < 37);
        if (char_reqs.size() != 0 && !idle) begin
          in_valid     <= 1'b1;
          in_char_code <= char_reqs[0].ch;
          in_is_final  <= char_reqs[0].fin;
          void'(char_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once, so the encoder backs up into its input.
  always @(posedge clk) begin
    if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every accepted symbol against the oldest prediction.
  always @(posedge clk) begin : monitor
    morse_sym_t want;
    bit         stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (symbols_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected symbol %0d", out_symbol));
        end else begin
          want = symbols_due.pop_front();
          if (out_symbol !== want.sym)
            flag_mismatch($sformatf("symbol %0d, predicted %0d", out_symbol, want.sym));
          if (out_last_of_run !== want.last)
            flag_mismatch($sformatf("last_of_run %0b, predicted %0b",
                                    out_last_of_run, want.last));
          if (out_no_symbol !== want.none)
            flag_mismatch($sformatf("no_symbol %0b, predicted %0b",
                                    out_no_symbol, want.none));
        end
        results_seen <= results_seen + 1;
      end
      stall = (results_seen < 800 || results_seen >= 1200) && ($urandom_range(99) < 37);
      out_ready <= (hold_left == 0) && !stall;
    end
  end

  initial begin : timeout
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    string      charset;
    int         msg_len;
    bit         broken;
    logic [7:0] c;
    logic       fin;

    // Directed requests: case folding, unknown and high bytes, spaces,
    // the longest codes, parentheses, and messages starting after a final.
    queue_char("E", 1'b0);
    queue_char("Z", 1'b0);
    queue_char("a", 1'b0);
    queue_char(" ", 1'b0);
    queue_char(".", 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char("(", 1'b0);
    queue_char(")", 1'b1);
    queue_char(8'h80, 1'b1);
    queue_char(" ", 1'b1);
    queue_char(" ", 1'b0);
    queue_char(8'h7F, 1'b1);
    queue_char(8'h01, 1'b0);
    queue_char("@", 1'b0);
    queue_char(",", 1'b0);
    queue_char("0", 1'b0);
    queue_char("9", 1'b0);
    queue_char("w", 1'b0);
    queue_char("!", 1'b0);
    queue_char("?", 1'b1);

    // Random messages, mostly well formed; some lack a final or end early,
    // and a fifth of the characters are arbitrary bytes.
    charset = {"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
               "0123456789.,:;()\"-/?!@   "};
    while (char_reqs.size() < 21 + RANDOM_ITEMS) begin
      msg_len = $urandom_range(12, 1);
      broken  = ($urandom_range(99) < 10);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(99) < 20) c = 8'($urandom_range(255));
        else c = charset[$urandom_range(charset.len() - 1)];
        fin = (i == msg_len - 1) ? !broken : ($urandom_range(99) < 3);
        queue_char(c, fin);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (char_reqs.size() != 0 || in_valid || symbols_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
